[hw/rtl/lru_cache_table_core_assert.svh]
// Assertion macros for the LRU cache table RTL.
// Needs a clock named clock and an active high reset named reset in the using scope.
`ifndef LRU_CACHE_TABLE_CORE_ASSERT_SVH
`define LRU_CACHE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LCT_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru cache table: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define LCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lru cache table: next-cycle check failed");

`endif

[hw/rtl/lct_pkg.sv]
// Shared types and constants for the LRU cache table.
// No dependencies; imported by the interfaces, the core and the sequencer.
package lct_pkg;

   localparam int KEY_W = 32;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_RETRIEVE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } lct_state_type;

   typedef struct packed {
      logic req_ready;
      logic start;
      logic rd_en;
      logic cmp_en;
      logic decide;
      logic wb_en;
      logic finish;
   } lct_ctrl_type;

endpackage

[hw/rtl/lct_if.sv]
// Channel interfaces for the LRU cache table: request, response and capacity write.
// Depends on lct_pkg.
interface lct_req_if #(parameter int VALUE_BITS = 32) ();
   import lct_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    op;
   logic signed [KEY_W-1:0] key;
   logic [VALUE_BITS-1:0]   value;
   modport source (output valid, output op, output key, output value, input ready);
   modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lct_rsp_if #(parameter int VALUE_BITS = 32) ();
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [VALUE_BITS-1:0] read_value;
   modport source (output valid, output found, output read_value, input ready);
   modport sink   (input valid, input found, input read_value, output ready);
endinterface

interface lct_csr_if ();
   import lct_pkg::*;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/lru_cache_table_core.sv]
// LRU cache table: one transaction at a time, as a request is taken only when idle.
// Each transaction makes two sweeps over the single read port of the rank memory:
// a search sweep, then a read-modify-write sweep of the ranks (none on a retrieve miss).
// Reset (synchronous, active high) empties the table and sets the capacity to 16;
// no clearing pass is needed, as the valid bits live in flip-flops.
module lru_cache_table_core #(
   parameter int ENTRIES    = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   lct_req_if.sink    req_ch,
   lct_rsp_if.source  rsp_ch,
   lct_csr_if.sink    csr_ch
);
   import lct_pkg::*;

`include "lru_cache_table_core_assert.svh"

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int KV_W  = KEY_W + VALUE_BITS;
   localparam int OUT_W = 32;

   lct_ctrl_type ctrl;
   logic [IDX_W-1:0] rd_addr, cmp_idx;

   // capacity register
   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] live_cap;

   // transaction captured at acceptance
   logic                  op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VALUE_BITS-1:0] val_ff;

   // search results
   logic                  hit_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [IDX_W-1:0]      hit_rank_ff;
   logic [VALUE_BITS-1:0] hit_val_ff;

   // table bookkeeping
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   keep_ff, keep_in;
   logic               placed_ff, placed_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_free;

   // memory ports
   logic             kv_wr_en;
   logic [IDX_W-1:0] kv_wr_addr;
   logic [KV_W-1:0]  kv_wr_data, kv_rd_data;
   logic             rank_wr_en;
   logic [IDX_W-1:0] rank_wr_data, rank_rd;

   logic insert_new, skip_update;
   logic cur_valid, cur_evict;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   assign skip_update = (op_ff == OP_RETRIEVE) && !hit_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_ch.ready;

   lct_fsm #(.ENTRIES(ENTRIES)) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .skip_update (skip_update),
      .rsp_free    (rsp_free),
      .ctrl        (ctrl),
      .rd_addr     (rd_addr),
      .cmp_idx     (cmp_idx)
   );

   assign req_ch.ready = ctrl.req_ready;
   assign csr_ch.ready = 1'b1;

   // ---------------------------------------------------------------
   // Memories: key and value words together, recency ranks apart
   // ---------------------------------------------------------------
   lct_ram #(.WIDTH(KV_W), .DEPTH(ENTRIES)) u_kv_ram (
      .clock   (clock),
      .wr_en   (kv_wr_en),
      .wr_addr (kv_wr_addr),
      .wr_data (kv_wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (kv_rd_data)
   );

   lct_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (cmp_idx),
      .wr_data (rank_wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rank_rd)
   );

   // Clamp the capacity: zero acts as one, anything above ENTRIES as ENTRIES
   always_comb begin
      if (cap_ff == '0) begin
         live_cap = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         live_cap = CNT_W'(ENTRIES);
      end else begin
         live_cap = CNT_W'(cap_ff);
      end
   end

   // An insert of an absent key fills a slot; any hit promotes the hit slot; a retrieve miss changes nothing
   assign insert_new = (op_ff == OP_INSERT) && !hit_ff;

   // Decide how many of the most recent entries survive an insert of a new key:
   // every valid slot whose rank reaches the limit is evicted in the update sweep.
   always_comb begin
      keep_in = keep_ff;
      if (ctrl.decide) begin
         keep_in = (count_ff >= live_cap) ? CNT_W'(live_cap - CNT_W'(1)) : count_ff;
      end
   end

   // ---------------------------------------------------------------
   // Update sweep: read the rank, modify, write back one slot per cycle.
   // The write of slot i coincides with the read of slot i+1, so no
   // forwarding is needed.
   // ---------------------------------------------------------------
   assign cur_valid = valid_ff[cmp_idx];
   assign cur_evict = cur_valid && (CNT_W'(rank_rd) >= keep_ff);

   always_comb begin
      rank_wr_en   = 1'b0;
      rank_wr_data = '0;
      kv_wr_en     = 1'b0;
      kv_wr_addr   = hit_idx_ff;
      kv_wr_data   = {key_ff, val_ff};
      valid_in     = valid_ff;
      placed_in    = placed_ff;
      if (ctrl.decide) begin
         placed_in = 1'b0;
         // replace the value of a present key in place
         if ((op_ff == OP_INSERT) && hit_ff) begin
            kv_wr_en = 1'b1;
         end
      end
      if (ctrl.wb_en) begin
         if (insert_new) begin
            if (!placed_ff && (!cur_valid || cur_evict)) begin
               // take the first free or freed slot as the most recent entry
               rank_wr_en        = 1'b1;
               kv_wr_en          = 1'b1;
               kv_wr_addr        = cmp_idx;
               valid_in[cmp_idx] = 1'b1;
               placed_in         = 1'b1;
            end else if (cur_evict) begin
               valid_in[cmp_idx] = 1'b0;
            end else if (cur_valid) begin
               // age every survivor by one
               rank_wr_en   = 1'b1;
               rank_wr_data = IDX_W'(rank_rd + IDX_W'(1));
            end
         end else begin
            if (cmp_idx == hit_idx_ff) begin
               rank_wr_en = 1'b1;
            end else if (cur_valid && (rank_rd < hit_rank_ff)) begin
               // age only those more recent than the promoted slot
               rank_wr_en   = 1'b1;
               rank_wr_data = IDX_W'(rank_rd + IDX_W'(1));
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response register: parts the pipeline from the response channel
   // ---------------------------------------------------------------
   always_comb begin
      rsp_value_in = '0;
      // a result is at most 32 bits wide; drop any bits above
      for (int b = 0; b < VALUE_BITS; b++) begin
         if (b < OUT_W) begin
            rsp_value_in[b] = (op_ff == OP_RETRIEVE) && hit_ff && hit_val_ff[b];
         end
      end
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.read_value = rsp_value_ff;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         valid_ff     <= '0;
         placed_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            cap_ff <= csr_ch.data;
         end
         valid_ff     <= valid_in;
         placed_ff    <= placed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.decide && insert_new) begin
            count_ff <= CNT_W'(keep_in + CNT_W'(1));
         end
         if (ctrl.start) begin
            hit_ff <= 1'b0;
         end else if (ctrl.cmp_en && !hit_ff && cur_valid
                      && (kv_rd_data[KV_W-1:VALUE_BITS] == key_ff)) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      keep_ff <= keep_in;
      if (ctrl.start) begin
         op_ff  <= req_ch.op;
         key_ff <= req_ch.key;
         val_ff <= req_ch.value;
      end
      // capture the first matching slot of the search sweep
      if (ctrl.cmp_en && !hit_ff && cur_valid
          && (kv_rd_data[KV_W-1:VALUE_BITS] == key_ff)) begin
         hit_idx_ff  <= cmp_idx;
         hit_rank_ff <= rank_rd;
         hit_val_ff  <= kv_rd_data[VALUE_BITS-1:0];
      end
      if (ctrl.finish) begin
         rsp_found_ff <= (op_ff == OP_INSERT) || hit_ff;
         rsp_value_ff <= rsp_value_in;
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // between transactions the count matches the number of valid slots
   `LCT_ASSERT_IMPLY(a_count_matches_valid, ctrl.req_ready, $countones(valid_ff) == 32'(count_ff))
   // a finished transaction never overwrites a waiting response
   `LCT_ASSERT_IMPLY(a_no_rsp_overwrite, ctrl.finish, !rsp_valid_ff || rsp_ch.ready)
   // an insert of a new key has found a slot by the time it finishes
   `LCT_ASSERT_IMPLY(a_new_key_placed, ctrl.finish && insert_new, placed_ff)
   // a finished transaction shows its response in the next cycle
   `LCT_ASSERT_NEXT(a_rsp_follows_finish, ctrl.finish, rsp_valid_ff)

endmodule

[hw/rtl/lct_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/lct_fsm.sv]
// Sequencer for the LRU cache table: search sweep, decision, update sweep (skipped on a retrieve miss), finish.
// Depends on lct_pkg.
module lct_fsm #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       skip_update,
   input  logic                       rsp_free,
   output lct_pkg::lct_ctrl_type      ctrl,
   output logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [$clog2(ENTRIES)-1:0] cmp_idx
);
   import lct_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES);

   lct_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]  pipe_idx_ff;
   logic              sweeping;

   assign sweeping = (state_ff == ST_SEARCH) || (state_ff == ST_UPDATE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SEARCH;
         ST_SEARCH: if (scan_ff == LAST) state_in = ST_DECIDE;
         ST_DECIDE: state_in = skip_update ? ST_FINISH : ST_UPDATE;
         ST_UPDATE: if (scan_ff == LAST) state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sweep counter and read pipeline
   always_comb begin
      pipe_vld_in = sweeping && (scan_ff != LAST);
      if (sweeping) begin
         scan_in = pipe_vld_in ? CNT_W'(scan_ff + CNT_W'(1)) : scan_ff;
      end else begin
         scan_in = '0;
      end
   end

   // outputs
   always_comb begin
      ctrl.req_ready = (state_ff == ST_IDLE);
      ctrl.start     = (state_ff == ST_IDLE) && req_valid;
      ctrl.rd_en     = pipe_vld_in;
      ctrl.cmp_en    = (state_ff == ST_SEARCH) && pipe_vld_ff;
      ctrl.decide    = (state_ff == ST_DECIDE);
      ctrl.wb_en     = (state_ff == ST_UPDATE) && pipe_vld_ff;
      ctrl.finish    = (state_ff == ST_FINISH) && rsp_free;
   end

   assign rd_addr = scan_ff[IDX_W-1:0];
   assign cmp_idx = pipe_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_ff     <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_ff     <= scan_in;
         pipe_vld_ff <= pipe_vld_in;
      end
      pipe_idx_ff <= scan_ff[IDX_W-1:0];
   end
endmodule
